@@ sv/chpi_pkg.sv @@
// Shared types and constants for the cubic Hermite position interpolator.
// No dependencies; every other file imports this package.
package chpi_pkg;

    localparam int TIME_W = 32;
    localparam int STEP_W = 24;
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 10;
    localparam int POS_W  = 32;
    localparam int VEL_W  = 32;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_STEP  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [2:0][POS_W-1:0] chpi_vec3_t;

    typedef struct packed {
        chpi_vec3_t pos;
        chpi_vec3_t vel;
    } chpi_entry_t;

    // what travels beside the divider: command, early range flag, load word
    typedef struct packed {
        logic             is_query;
        logic             bad;
        logic [IDX_W-1:0] idx;
        chpi_entry_t      ent;
    } chpi_side_t;

endpackage

@@ sv/chpi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on chpi_pkg. Quotient of {num, FRACTION_BITS zeros} / step.
module chpi_div #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [chpi_pkg::STEP_W-1:0]               step,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [chpi_pkg::TIME_W-1:0]               in_num,
    input  chpi_pkg::chpi_side_t                      in_side,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [chpi_pkg::TIME_W+FRACTION_BITS-1:0] out_quo,
    output chpi_pkg::chpi_side_t                      out_side
);
    import chpi_pkg::*;

    localparam int QW = TIME_W + FRACTION_BITS;

    logic [QW-1:0]             v_reg;
    logic [QW-1:0]             en;
    logic [QW-1:0][STEP_W-1:0] r_reg, r_next;
    logic [QW-1:0][QW-1:0]     dq_reg, dq_next;
    chpi_side_t                side_reg [QW];

    always_comb
    begin
        en[QW-1] = !v_reg[QW-1] || out_ready;
        for (int k = QW - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        logic [STEP_W-1:0] src_r;
        logic [QW-1:0]     src_dq;
        logic [STEP_W:0]   trial;
        logic [STEP_W:0]   diff;
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                src_r  = '0;
                src_dq = {in_num, {FRACTION_BITS{1'b0}}};
            end
            else
            begin
                src_r  = r_reg[(k == 0) ? 0 : k - 1];
                src_dq = dq_reg[(k == 0) ? 0 : k - 1];
            end
            trial = {src_r, src_dq[QW-1]};
            diff  = trial - {1'b0, step};
            if (trial >= {1'b0, step})
            begin
                r_next[k]  = diff[STEP_W-1:0];
                dq_next[k] = {src_dq[QW-2:0], 1'b1};
            end
            else
            begin
                r_next[k]  = trial[STEP_W-1:0];
                dq_next[k] = {src_dq[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < QW; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= in_side;
        end
        for (int k = 1; k < QW; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        for (int k = 0; k < QW; k++)
        begin
            if (en[k])
            begin
                r_reg[k]  <= r_next[k];
                dq_reg[k] <= dq_next[k];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[QW-1];
    assign out_quo   = dq_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

@@ sv/chpi_table.sv @@
// Sample table: one write port for loads, two registered read ports for
// the two samples around a query's segment. Depends on chpi_pkg.
module chpi_table #(
    parameter int TABLE_DEPTH   = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [chpi_pkg::TIME_W-1:0]               last_seg,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [chpi_pkg::TIME_W+FRACTION_BITS-1:0] in_quo,
    input  chpi_pkg::chpi_side_t                      in_side,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic                                      out_bad,
    output logic [FRACTION_BITS-1:0]                  out_u,
    output chpi_pkg::chpi_vec3_t                      out_p0,
    output chpi_pkg::chpi_vec3_t                      out_v0,
    output chpi_pkg::chpi_vec3_t                      out_p1,
    output chpi_pkg::chpi_vec3_t                      out_v1
);
    import chpi_pkg::*;

    localparam int IDXW = $clog2(TABLE_DEPTH);

    chpi_entry_t        mem [TABLE_DEPTH];
    chpi_entry_t        rd0_reg, rd1_reg;
    logic               v_reg;
    logic               bad_reg;
    logic [FRACTION_BITS-1:0] u_reg;
    logic               en;
    logic               wr_en;
    logic [TIME_W-1:0]  seg;
    logic [IDXW-1:0]    addr0, addr1, waddr;

    assign en    = !v_reg || out_ready;
    assign seg   = in_quo[TIME_W+FRACTION_BITS-1:FRACTION_BITS];
    assign addr0 = seg[IDXW-1:0];
    assign addr1 = addr0 + 1'b1;
    assign waddr = IDXW'(in_side.idx);
    assign wr_en = in_valid && en && !in_side.is_query
                   && (TIME_W'(in_side.idx) < TIME_W'(TABLE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            // loads end here
            v_reg <= in_valid && in_side.is_query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= in_side.ent;
        end
        if (en)
        begin
            rd0_reg <= mem[addr0];
            rd1_reg <= mem[addr1];
            bad_reg <= in_side.bad || (seg >= last_seg);
            u_reg   <= in_quo[FRACTION_BITS-1:0];
        end
    end

    assign in_ready  = en;
    assign out_valid = v_reg;
    assign out_bad   = bad_reg;
    assign out_u     = u_reg;
    assign out_p0    = rd0_reg.pos;
    assign out_v0    = rd0_reg.vel;
    assign out_p1    = rd1_reg.pos;
    assign out_v1    = rd1_reg.vel;

endmodule

@@ sv/chpi_eval.sv @@
// Hermite basis, products, sum, rounding and saturation over seven stages.
// Depends on chpi_pkg.
module chpi_eval #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [chpi_pkg::STEP_W-1:0] step,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_bad,
    input  logic [FRACTION_BITS-1:0]    in_u,
    input  chpi_pkg::chpi_vec3_t        in_p0,
    input  chpi_pkg::chpi_vec3_t        in_v0,
    input  chpi_pkg::chpi_vec3_t        in_p1,
    input  chpi_pkg::chpi_vec3_t        in_v1,
    output logic                        out_valid,
    input  logic                        out_ready,
    output chpi_pkg::chpi_vec3_t        out_pos,
    output logic                        out_status
);
    import chpi_pkg::*;

    localparam int F    = FRACTION_BITS;
    localparam int HW   = F + 3;
    localparam int VDW  = VEL_W + STEP_W + 1;
    localparam int LOW  = 28;
    localparam int HIW  = VDW - LOW;
    localparam int PPW  = POS_W + HW;
    localparam int VLW  = LOW + 1 + HW;
    localparam int VHW  = HIW + HW;
    localparam int ACCW = F + 64;
    localparam int SH   = 16 + F;
    localparam int NST  = 7;
    localparam logic [2*F-1:0]         HALF = (2*F)'(1) << (F - 1);
    localparam logic signed [ACCW-1:0] RND  = ACCW'(1) << (SH - 1);
    localparam logic signed [HW-1:0]   ONE  = HW'(1) << F;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;
    logic [NST-1:0] bad_reg;

    // stage a
    logic [F-1:0]                u_a_reg, u2_a_next, u2_a_reg;
    chpi_vec3_t                  p0_a_reg, p1_a_reg;
    logic signed [2:0][VDW-1:0]  vd0_a_next, vd1_a_next, vd0_a_reg, vd1_a_reg;
    // stage b
    logic [F-1:0]                u_b_reg, u2_b_reg, u3_b_next, u3_b_reg;
    chpi_vec3_t                  p0_b_reg, p1_b_reg;
    logic signed [2:0][VDW-1:0]  vd0_b_reg, vd1_b_reg;
    // stage c
    logic signed [HW-1:0]        h00_next, h10_next, h01_next, h11_next;
    logic signed [HW-1:0]        h00_reg, h10_reg, h01_reg, h11_reg;
    chpi_vec3_t                  p0_c_reg, p1_c_reg;
    logic signed [2:0][VDW-1:0]  vd0_c_reg, vd1_c_reg;
    // stage d
    logic signed [2:0][PPW-1:0]  pp0_next, pp1_next, pp0_reg, pp1_reg;
    logic signed [2:0][VLW-1:0]  vl0_next, vl1_next, vl0_reg, vl1_reg;
    logic signed [2:0][VHW-1:0]  vh0_next, vh1_next, vh0_reg, vh1_reg;
    // stage e
    logic signed [2:0][ACCW-1:0] ps_next, vt0_next, vt1_next;
    logic signed [2:0][ACCW-1:0] ps_reg, vt0_reg, vt1_reg;
    // stage f
    logic signed [2:0][ACCW-1:0] sum_next, sum_reg;
    // output
    chpi_vec3_t                  pos_next, pos_reg;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        logic [2*F-1:0]          sq;
        logic [2*F-1:0]          cu;
        logic signed [HW-1:0]    uu, uu2, uu3;
        logic signed [ACCW-1:0]  shr;
        logic [ACCW-POS_W:0]     top;

        sq        = in_u * in_u + HALF;
        u2_a_next = sq[2*F-1:F];
        for (int k = 0; k < 3; k++)
        begin
            vd0_a_next[k] = $signed(in_v0[k]) * $signed({1'b0, step});
            vd1_a_next[k] = $signed(in_v1[k]) * $signed({1'b0, step});
        end

        cu        = u2_a_reg * u_a_reg + HALF;
        u3_b_next = cu[2*F-1:F];

        uu  = $signed(HW'(u_b_reg));
        uu2 = $signed(HW'(u2_b_reg));
        uu3 = $signed(HW'(u3_b_reg));
        h00_next = ONE - uu2 - (uu2 <<< 1) + (uu3 <<< 1);
        h10_next = uu - (uu2 <<< 1) + uu3;
        h01_next = uu2 + (uu2 <<< 1) - (uu3 <<< 1);
        h11_next = uu3 - uu2;

        // elements of a packed array are unsigned, so sign them before widening
        for (int k = 0; k < 3; k++)
        begin
            pp0_next[k] = $signed(p0_c_reg[k]) * h00_reg;
            pp1_next[k] = $signed(p1_c_reg[k]) * h01_reg;
            vl0_next[k] = $signed({1'b0, vd0_c_reg[k][LOW-1:0]}) * h10_reg;
            vh0_next[k] = $signed(vd0_c_reg[k][VDW-1:LOW]) * h10_reg;
            vl1_next[k] = $signed({1'b0, vd1_c_reg[k][LOW-1:0]}) * h11_reg;
            vh1_next[k] = $signed(vd1_c_reg[k][VDW-1:LOW]) * h11_reg;

            ps_next[k]  = (ACCW'($signed(pp0_reg[k])) + ACCW'($signed(pp1_reg[k]))) <<< 16;
            vt0_next[k] = (ACCW'($signed(vh0_reg[k])) <<< LOW) + ACCW'($signed(vl0_reg[k]));
            vt1_next[k] = (ACCW'($signed(vh1_reg[k])) <<< LOW) + ACCW'($signed(vl1_reg[k]));

            sum_next[k] = ps_reg[k] + vt0_reg[k] + vt1_reg[k] + RND;

            shr = $signed(sum_reg[k]) >>> SH;
            top = shr[ACCW-1:POS_W-1];
            if (bad_reg[NST-2])
            begin
                pos_next[k] = '0;
            end
            else if ((&top) || !(|top))
            begin
                pos_next[k] = shr[POS_W-1:0];
            end
            else if (shr[ACCW-1])
            begin
                pos_next[k] = {1'b1, {(POS_W-1){1'b0}}};
            end
            else
            begin
                pos_next[k] = {1'b0, {(POS_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            bad_reg[0] <= in_bad;
            u_a_reg    <= in_u;
            u2_a_reg   <= u2_a_next;
            p0_a_reg   <= in_p0;
            p1_a_reg   <= in_p1;
            vd0_a_reg  <= vd0_a_next;
            vd1_a_reg  <= vd1_a_next;
        end
        if (en[1])
        begin
            bad_reg[1] <= bad_reg[0];
            u_b_reg    <= u_a_reg;
            u2_b_reg   <= u2_a_reg;
            u3_b_reg   <= u3_b_next;
            p0_b_reg   <= p0_a_reg;
            p1_b_reg   <= p1_a_reg;
            vd0_b_reg  <= vd0_a_reg;
            vd1_b_reg  <= vd1_a_reg;
        end
        if (en[2])
        begin
            bad_reg[2] <= bad_reg[1];
            h00_reg    <= h00_next;
            h10_reg    <= h10_next;
            h01_reg    <= h01_next;
            h11_reg    <= h11_next;
            p0_c_reg   <= p0_b_reg;
            p1_c_reg   <= p1_b_reg;
            vd0_c_reg  <= vd0_b_reg;
            vd1_c_reg  <= vd1_b_reg;
        end
        if (en[3])
        begin
            bad_reg[3] <= bad_reg[2];
            pp0_reg    <= pp0_next;
            pp1_reg    <= pp1_next;
            vl0_reg    <= vl0_next;
            vl1_reg    <= vl1_next;
            vh0_reg    <= vh0_next;
            vh1_reg    <= vh1_next;
        end
        if (en[4])
        begin
            bad_reg[4] <= bad_reg[3];
            ps_reg     <= ps_next;
            vt0_reg    <= vt0_next;
            vt1_reg    <= vt1_next;
        end
        if (en[5])
        begin
            bad_reg[5] <= bad_reg[4];
            sum_reg    <= sum_next;
        end
        if (en[6])
        begin
            bad_reg[6] <= bad_reg[5];
            pos_reg    <= pos_next;
        end
    end

    assign in_ready   = en[0];
    assign out_valid  = v_reg[NST-1];
    assign out_pos    = pos_reg;
    assign out_status = bad_reg[NST-1];

endmodule

@@ sv/cubic_hermite_position_interpolator_unit.sv @@
// Cubic Hermite position interpolator, top level: config port, entry checks.
// Path from accepted word to result: one divider stage per quotient bit,
// one table read, seven math stages. Throughput: one word per cycle while
// req_stall is low; loads and queries share the pipeline in order.
// Reset clears config to start 0, step 1, count 2 and empties the pipeline;
// table contents are not cleared. Depends on chpi_pkg, chpi_div/table/eval.
module cubic_hermite_position_interpolator_unit #(
    parameter int TABLE_DEPTH   = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [chpi_pkg::ADDR_W-1:0]        paddr,
    input  logic [chpi_pkg::DATA_W-1:0]        pwdata,
    output logic [chpi_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic                               func,
    input  logic [chpi_pkg::IDX_W-1:0]         entry_index,
    input  logic signed [chpi_pkg::POS_W-1:0]  load_pos_x,
    input  logic signed [chpi_pkg::POS_W-1:0]  load_pos_y,
    input  logic signed [chpi_pkg::POS_W-1:0]  load_pos_z,
    input  logic signed [chpi_pkg::VEL_W-1:0]  load_vel_x,
    input  logic signed [chpi_pkg::VEL_W-1:0]  load_vel_y,
    input  logic signed [chpi_pkg::VEL_W-1:0]  load_vel_z,
    input  logic [chpi_pkg::TIME_W-1:0]        query_time,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic signed [chpi_pkg::POS_W-1:0]  out_x,
    output logic signed [chpi_pkg::POS_W-1:0]  out_y,
    output logic signed [chpi_pkg::POS_W-1:0]  out_z,
    output logic                               status
);
    import chpi_pkg::*;

    localparam int QW = TIME_W + FRACTION_BITS;

    logic [TIME_W-1:0] start_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              wr;
    logic [TIME_W-1:0] cnt_ext, eff_cnt, last_seg, offset;
    chpi_side_t        side;
    logic              div_ready, div_valid, tab_ready, tab_valid, ev_ready;
    logic [QW-1:0]     div_quo;
    chpi_side_t        div_side;
    logic              tab_bad;
    logic [FRACTION_BITS-1:0] tab_u;
    chpi_vec3_t        tab_p0, tab_v0, tab_p1, tab_v1, res_pos;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            step_reg  <= STEP_W'(1);
            count_reg <= CNT_W'(2);
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_START: start_reg <= pwdata[TIME_W-1:0];
                REG_STEP:  step_reg  <= pwdata[STEP_W-1:0];
                REG_COUNT: count_reg <= pwdata[CNT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_START: prdata = DATA_W'(start_reg);
            REG_STEP:  prdata = DATA_W'(step_reg);
            REG_COUNT: prdata = DATA_W'(count_reg);
            default:   prdata = '0;
        endcase
    end

    assign cnt_ext  = TIME_W'(count_reg);
    assign eff_cnt  = (cnt_ext > TIME_W'(TABLE_DEPTH)) ? TIME_W'(TABLE_DEPTH) : cnt_ext;
    assign last_seg = eff_cnt - 1'b1;
    assign offset   = query_time - start_reg;

    always_comb
    begin
        side.is_query   = (func == FUNC_QUERY);
        side.bad        = (query_time < start_reg) || (step_reg == '0)
                          || (eff_cnt < TIME_W'(2));
        side.idx        = entry_index;
        side.ent.pos[0] = load_pos_x;
        side.ent.pos[1] = load_pos_y;
        side.ent.pos[2] = load_pos_z;
        side.ent.vel[0] = load_vel_x;
        side.ent.vel[1] = load_vel_y;
        side.ent.vel[2] = load_vel_z;
    end

    chpi_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step_reg),
        .in_valid  (req_valid),
        .in_ready  (div_ready),
        .in_num    (offset),
        .in_side   (side),
        .out_valid (div_valid),
        .out_ready (tab_ready),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    chpi_table #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .last_seg  (last_seg),
        .in_valid  (div_valid),
        .in_ready  (tab_ready),
        .in_quo    (div_quo),
        .in_side   (div_side),
        .out_valid (tab_valid),
        .out_ready (ev_ready),
        .out_bad   (tab_bad),
        .out_u     (tab_u),
        .out_p0    (tab_p0),
        .out_v0    (tab_v0),
        .out_p1    (tab_p1),
        .out_v1    (tab_v1)
    );

    chpi_eval #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step_reg),
        .in_valid   (tab_valid),
        .in_ready   (ev_ready),
        .in_bad     (tab_bad),
        .in_u       (tab_u),
        .in_p0      (tab_p0),
        .in_v0      (tab_v0),
        .in_p1      (tab_p1),
        .in_v1      (tab_v1),
        .out_valid  (rsp_valid),
        .out_ready  (!rsp_stall),
        .out_pos    (res_pos),
        .out_status (status)
    );

    assign req_stall = !div_ready;
    assign out_x     = res_pos[0];
    assign out_y     = res_pos[1];
    assign out_z     = res_pos[2];

endmodule
